/* hw/rtl/segregated_freelist_allocator_macros.svh */
// assertion macros for the segregated free-list allocator
// no dependencies
`ifndef SEGREGATED_FREELIST_ALLOCATOR_MACROS_SVH
`define SEGREGATED_FREELIST_ALLOCATOR_MACROS_SVH
`define SFA_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("sfa check failed");
`define SFA_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("sfa check failed");
`endif

/* hw/rtl/sfa_pkg.sv */
// shared constants for the segregated free-list allocator
// no dependencies
package sfa_pkg;
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOM  = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;
   localparam logic [1:0] ST_ZERO = 2'd3;
   localparam int MIN_CLASS_BYTES = 16;
   localparam int CLASS_LIMIT = 16;
endpackage

/* hw/rtl/segregated_freelist_allocator.sv */
// segregated free-list allocator: top level with record memory and walk sequencer
// depends on sfa_pkg and segregated_freelist_allocator_macros.svh
//
// Usage: one request channel (req_action, req_request_size, req_payload_offset) and one
// response channel (status, granted offset and usage counters), both valid/ready.
// Every transfer on req_ gives exactly one transfer on rsp_, in order.
// Paths: zero size or a malformed free offset is answered without touching the record
// memory; a free reads the record and answers ST_BAD if its tag is clear, else pushes the
// block onto its class list or the large list; an allocation takes the head of its class
// list, or walks the large list one record per cycle through the single record memory
// port and cuts the block, answering ST_OOM when the list is empty or no block fits.
// Throughput: one request at a time; req_ready is low from acceptance until the
// response has been taken and comes back in the cycle after the rsp_ transfer.
// Reset: synchronous, active high. A clearing pass then writes every record (8192 at
// the default heap), one per cycle, leaving the whole heap as one free block at granule 0
// with all tags clear; req_ready stays low meanwhile. Class lists are empty and counters
// are zero.
// Stall: while rsp_ready is low the response holds and no new request is taken.
// The record memory holds size, requested size, link and tag per granule.
`include "segregated_freelist_allocator_macros.svh"
module segregated_freelist_allocator #(
   parameter int HEAP_BYTES    = 65536,
   parameter int HEADER_BYTES  = 24,
   parameter int CLASS_COUNT   = 8,
   parameter int GRANULE_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [16:0] req_request_size,
   input  logic [15:0] req_payload_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_offset,
   output logic [16:0] rsp_bytes_in_use,
   output logic [16:0] rsp_peak_bytes_in_use,
   output logic [16:0] rsp_requested_in_use,
   output logic [16:0] rsp_peak_req_in_use,
   output logic [31:0] rsp_alloc_count,
   output logic [31:0] rsp_free_count,
   output logic [31:0] rsp_fail_count
);
   localparam int SLOTS = HEAP_BYTES / GRANULE_BYTES;
   localparam int SW = $clog2(SLOTS);
   localparam int GS = $clog2(GRANULE_BYTES);
   localparam int BW = $clog2(HEAP_BYTES) + 1;
   localparam int NC = (CLASS_COUNT < sfa_pkg::CLASS_LIMIT) ? CLASS_COUNT
                       : sfa_pkg::CLASS_LIMIT;
   localparam int CW = (NC > 1) ? $clog2(NC) : 1;
   localparam int CNT = 32;

   typedef struct packed {
      logic [BW-1:0] size;
      logic [16:0]   req;
      logic [SW-1:0] link;
      logic          link_ok;
      logic          tag;
   } rec_type;

   typedef enum logic [11:0] {
      S_INIT  = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_DEC   = 12'b000000000100,
      S_CLS   = 12'b000000001000,
      S_WRD   = 12'b000000010000,
      S_WCHK  = 12'b000000100000,
      S_UNL   = 12'b000001000000,
      S_REM   = 12'b000010000000,
      S_COMMIT= 12'b000100000000,
      S_FRD   = 12'b001000000000,
      S_FPUSH = 12'b010000000000,
      S_RSP   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   rec_type mem [SLOTS];
   logic             mem_we;
   logic [SW-1:0]    mem_wa, mem_ra;
   rec_type          mem_wd, rd_raw_ff;
   rec_type          rd;

   logic [SW-1:0] clr_ff;
   logic [SW-1:0] cls_head_ff [NC];
   logic [NC-1:0] cls_ne_ff;
   logic [SW-1:0] lhead_ff;
   logic          lne_ff;
   logic [CNT-1:0] u_ff [7];

   logic [16:0]   rq_ff;
   logic [BW-1:0] need_ff;
   logic          iscls_ff;
   logic [CW-1:0] cls_ff;
   logic [SW-1:0] cur_ff, prev_ff, slot_ff;
   logic          hasprev_ff;
   logic [SW:0]   steps_ff;
   logic [1:0]    st_ff;
   logic [15:0]   gr_ff;
   logic          rv_ff;
   rec_type       curr_ff, prec_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_raw_ff <= mem[mem_ra];
   end

   assign rd = rd_raw_ff;

   // request decode
   logic [17:0] total_w;
   logic [BW+17:0] tot_sum;
   logic          dec_cls_ok;
   logic [CW-1:0] dec_cls;
   logic          cls_hit;
   always_comb begin
      tot_sum = (BW+18)'(rq_ff) + (BW+18)'(HEADER_BYTES + GRANULE_BYTES - 1);
      total_w = 18'(tot_sum >> GS) << GS;
      dec_cls_ok = 1'b0;
      dec_cls = '0;
      for (int i = NC - 1; i >= 0; i--) begin
         if (32'(total_w) <= 32'(sfa_pkg::MIN_CLASS_BYTES << i)) begin
            dec_cls_ok = 1'b1;
            dec_cls = CW'(i);
         end
      end
   end
   assign cls_hit = dec_cls_ok && cls_ne_ff[dec_cls];

   // free decode
   logic [15:0] fb;
   logic        fbad;
   logic [SW-1:0] fslot;
   always_comb begin
      fb = req_payload_offset - 16'(HEADER_BYTES);
      fslot = SW'(fb >> GS);
      fbad = (req_payload_offset < 16'(HEADER_BYTES))
             || (fb[GS-1:0] != '0)
             || (32'(fb) >= 32'(HEAP_BYTES));
   end

   logic fcls_ok;
   logic [CW-1:0] fcls;
   always_comb begin
      fcls_ok = 1'b0;
      fcls = '0;
      for (int i = NC - 1; i >= 0; i--) begin
         if (rd.size == BW'(sfa_pkg::MIN_CLASS_BYTES << i)) begin
            fcls_ok = 1'b1;
            fcls = CW'(i);
         end
      end
   end

   logic [BW-1:0] rest_w;
   logic [SW:0]   rslot_w;
   assign rest_w = curr_ff.size - need_ff;
   assign rslot_w = (SW+1)'(cur_ff) + (SW+1)'(need_ff >> GS);

   assign req_ready = (state_ff == S_IDLE);
   logic acc;
   assign acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         clr_ff <= '0;
         cls_ne_ff <= '0;
         lhead_ff <= '0;
         lne_ff <= 1'b1;
         rv_ff <= 1'b0;
         for (int i = 0; i < 7; i++) u_ff[i] <= '0;
         for (int i = 0; i < NC; i++) cls_head_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= (state_in == S_RSP);
         case (state_ff)
            S_INIT: begin
               clr_ff <= clr_ff + 1'b1;
            end
            S_IDLE: begin
               if (acc) begin
                  rq_ff <= req_request_size;
                  gr_ff <= '0;
                  slot_ff <= fslot;
                  if (req_action && fbad) st_ff <= sfa_pkg::ST_BAD;
                  else if (!req_action && req_request_size == '0) st_ff <= sfa_pkg::ST_ZERO;
                  else st_ff <= sfa_pkg::ST_OK;
               end
            end
            S_DEC: begin
               iscls_ff <= dec_cls_ok;
               cls_ff <= dec_cls;
               if (dec_cls_ok) need_ff <= BW'(sfa_pkg::MIN_CLASS_BYTES << dec_cls);
               else if (32'(total_w) > 32'(HEAP_BYTES)) need_ff <= '1;
               else need_ff <= BW'(total_w);
               cur_ff <= lhead_ff;
               hasprev_ff <= 1'b0;
               steps_ff <= '0;
               if (cls_hit) slot_ff <= cls_head_ff[dec_cls];
               else if (!lne_ff) st_ff <= sfa_pkg::ST_OOM;
            end
            S_CLS: begin
               cls_head_ff[cls_ff] <= rd.link;
               cls_ne_ff[cls_ff] <= rd.link_ok;
            end
            S_WCHK: begin
               curr_ff <= rd;
               prec_ff <= curr_ff;
               if (rd.size < need_ff) begin
                  prev_ff <= cur_ff;
                  hasprev_ff <= 1'b1;
                  cur_ff <= rd.link;
                  steps_ff <= steps_ff + 1'b1;
                  if (!rd.link_ok || steps_ff + 1'b1 >= (SW+1)'(SLOTS)) begin
                     st_ff <= sfa_pkg::ST_OOM;
                  end
               end
            end
            S_UNL: begin
               slot_ff <= cur_ff;
               if (!hasprev_ff) begin
                  lhead_ff <= curr_ff.link;
                  lne_ff <= curr_ff.link_ok;
               end
            end
            S_REM: begin
               if (rest_w >= BW'(sfa_pkg::MIN_CLASS_BYTES) && rslot_w < (SW+1)'(SLOTS)) begin
                  lhead_ff <= SW'(rslot_w);
                  lne_ff <= 1'b1;
               end
            end
            S_COMMIT: begin
               if (st_ff == sfa_pkg::ST_OK) begin
                  u_ff[4] <= u_ff[4] + 1'b1;
                  u_ff[0] <= u_ff[0] + CNT'(need_ff);
                  if (u_ff[0] + CNT'(need_ff) > u_ff[1]) u_ff[1] <= u_ff[0] + CNT'(need_ff);
                  u_ff[2] <= u_ff[2] + CNT'(rq_ff);
                  if (u_ff[2] + CNT'(rq_ff) > u_ff[3]) u_ff[3] <= u_ff[2] + CNT'(rq_ff);
                  gr_ff <= 16'((CNT'(slot_ff) << GS) + CNT'(HEADER_BYTES));
               end else begin
                  u_ff[6] <= u_ff[6] + 1'b1;
               end
            end
            S_FRD: begin
               if (!rd.tag) st_ff <= sfa_pkg::ST_BAD;
            end
            S_FPUSH: begin
               u_ff[5] <= u_ff[5] + 1'b1;
               u_ff[0] <= u_ff[0] - CNT'(rd.size);
               u_ff[2] <= u_ff[2] - CNT'(rd.req);
               if (fcls_ok) begin
                  cls_head_ff[fcls] <= slot_ff;
                  cls_ne_ff[fcls] <= 1'b1;
               end else begin
                  lhead_ff <= slot_ff;
                  lne_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer and memory port
   always_comb begin
      state_in = state_ff;
      mem_we = 1'b0;
      mem_wa = slot_ff;
      mem_wd = rd;
      mem_ra = cur_ff;
      case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            if (clr_ff == '0) mem_wd.size = BW'(HEAP_BYTES);
            if (clr_ff == SW'(SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            mem_ra = fslot;
            if (acc) begin
               if (req_action) state_in = fbad ? S_RSP : S_FRD;
               else state_in = (req_request_size == '0) ? S_RSP : S_DEC;
            end
         end
         S_DEC: begin
            mem_ra = cls_hit ? cls_head_ff[dec_cls] : lhead_ff;
            if (cls_hit) state_in = S_CLS;
            else if (lne_ff) state_in = S_WCHK;
            else state_in = S_WRD;
         end
         S_CLS: begin
            mem_ra = slot_ff;
            state_in = S_COMMIT;
         end
         S_WRD: begin
            state_in = S_COMMIT;
         end
         S_WCHK: begin
            mem_ra = rd.link;
            if (rd.size >= need_ff) state_in = S_UNL;
            else if (!rd.link_ok || steps_ff + 1'b1 >= (SW+1)'(SLOTS)) state_in = S_COMMIT;
            else state_in = S_WCHK;
         end
         S_UNL: begin
            if (hasprev_ff) begin
               mem_we = 1'b1;
               mem_wa = prev_ff;
               mem_wd = prec_ff;
               mem_wd.link = curr_ff.link;
               mem_wd.link_ok = curr_ff.link_ok;
               mem_ra = prev_ff;
            end
            state_in = S_REM;
         end
         S_REM: begin
            mem_ra = cur_ff;
            if (rest_w >= BW'(sfa_pkg::MIN_CLASS_BYTES) && rslot_w < (SW+1)'(SLOTS)) begin
               mem_we = 1'b1;
               mem_wa = SW'(rslot_w);
               mem_wd = '0;
               mem_wd.size = rest_w;
               mem_wd.link = lhead_ff;
               mem_wd.link_ok = lne_ff;
            end
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            mem_ra = slot_ff;
            if (st_ff == sfa_pkg::ST_OK) begin
               mem_we = 1'b1;
               mem_wa = slot_ff;
               mem_wd.size = need_ff;
               mem_wd.req = rq_ff;
               mem_wd.link = iscls_ff ? rd.link : curr_ff.link;
               mem_wd.link_ok = iscls_ff ? rd.link_ok : curr_ff.link_ok;
               mem_wd.tag = 1'b1;
            end
            state_in = S_RSP;
         end
         S_FRD: begin
            mem_ra = slot_ff;
            state_in = rd.tag ? S_FPUSH : S_RSP;
         end
         S_FPUSH: begin
            mem_ra = slot_ff;
            mem_we = 1'b1;
            mem_wa = slot_ff;
            mem_wd = rd;
            mem_wd.link = fcls_ok ? cls_head_ff[fcls] : lhead_ff;
            mem_wd.link_ok = fcls_ok ? cls_ne_ff[fcls] : lne_ff;
            mem_wd.tag = 1'b0;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff && (state_ff == S_RSP);
   assign rsp_status = st_ff;
   assign rsp_granted_offset = gr_ff;
   assign rsp_bytes_in_use = u_ff[0][16:0];
   assign rsp_peak_bytes_in_use = u_ff[1][16:0];
   assign rsp_requested_in_use = u_ff[2][16:0];
   assign rsp_peak_req_in_use = u_ff[3][16:0];
   assign rsp_alloc_count = u_ff[4];
   assign rsp_free_count = u_ff[5];
   assign rsp_fail_count = u_ff[6];

   `SFA_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !rsp_valid)
   `SFA_ASSERT_IMP(a_grant_ok, clock, reset, rsp_valid && rsp_status != sfa_pkg::ST_OK,
      rsp_granted_offset == '0)
   `SFA_ASSERT_NEXT(a_rsp_done, clock, reset, rsp_valid && rsp_ready, req_ready)
endmodule
